// ----- hw/rtl/pr3_pkg.sv -----
// ----------------------------------------------------------------------------
// pr3_pkg
// shared constants for the 3x3 pyramid reduce block
// ----------------------------------------------------------------------------
package pr3_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int SUM_W = 12;

endpackage

// ----- hw/rtl/pr3_if.sv -----
// ----------------------------------------------------------------------------
// pr3_if
// valid/ready stream interfaces for input and output pixels
// ----------------------------------------------------------------------------
interface pr3_in_if;
  logic                       valid;
  logic                       ready;
  logic [pr3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pr3_out_if;
  logic                       valid;
  logic                       ready;
  logic [pr3_pkg::PIX_W-1:0]  pixel_out;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- hw/rtl/pyramid_reduce_3x3.sv -----
// ----------------------------------------------------------------------------
// pyramid_reduce_3x3
// one gaussian pyramid level: 3x3 binomial filter, decimated by two in x and y
// ----------------------------------------------------------------------------
// result path: input transfer -> stage 1 register -> output register; a stall
//   can hold stage 1. throughput: one pixel per cycle while not stalled; each
//   transfer reads both line memories and writes the one for its row parity
// reset: counters and window cleared, size back to 640x480; line memories
//   are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module pyramid_reduce_3x3 #(
  parameter int MAX_WIDTH  = pr3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pr3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [pr3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pr3_pkg::CFG_DATA_W-1:0]   cfg_data,
  pr3_in_if.sink                           pix_in,
  pr3_out_if.source                        pix_out
);

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int ROWW = $clog2(MAX_HEIGHT);
  localparam int WCMP = (COLW + 1 > pr3_pkg::WIDTH_REG_W) ? COLW + 1 : pr3_pkg::WIDTH_REG_W;
  localparam int HCMP = (ROWW + 1 > pr3_pkg::HEIGHT_REG_W) ? ROWW + 1 : pr3_pkg::HEIGHT_REG_W;
  localparam int PW   = pr3_pkg::PIX_W;
  localparam int SW   = pr3_pkg::SUM_W;

  // configuration
  logic [pr3_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [pr3_pkg::HEIGHT_REG_W-1:0] height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= pr3_pkg::WIDTH_RESET;
      height_reg <= pr3_pkg::HEIGHT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pr3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[pr3_pkg::WIDTH_REG_W-1:0];
        pr3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[pr3_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  logic [WCMP-1:0] w_ext;
  logic [HCMP-1:0] h_ext;
  logic [COLW:0]   w_eff, w_even;
  logic [ROWW:0]   h_eff, h_even;

  always_comb begin
    w_ext = WCMP'(width_reg);
    h_ext = HCMP'(height_reg);
    if (w_ext < WCMP'(2)) begin
      w_eff = (COLW+1)'(2);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = (COLW+1)'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[COLW:0];
    end
    if (h_ext < HCMP'(2)) begin
      h_eff = (ROWW+1)'(2);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = (ROWW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext[ROWW:0];
    end
    w_even = {w_eff[COLW:1], 1'b0};
    h_even = {h_eff[ROWW:1], 1'b0};
  end

  // stage 0: raster counters, memory access
  logic [COLW-1:0] col, col_next;
  logic [ROWW-1:0] row, row_next;
  logic            in_fire;
  logic            s1_go;
  logic            s1_valid;

  assign pix_in.ready = !s1_valid || s1_go;
  assign in_fire      = pix_in.valid && pix_in.ready;

  always_comb begin
    col_next = col + COLW'(1);
    row_next = row;
    if (({1'b0, col} + (COLW+1)'(1)) >= w_eff) begin
      col_next = '0;
      if (({1'b0, row} + (ROWW+1)'(1)) >= h_eff) begin
        row_next = '0;
      end else begin
        row_next = row + ROWW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

  logic [PW-1:0] even_q, odd_q;

  pr3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_even (
    .clk   (clk),
    .we    (in_fire && !row[0]),
    .waddr (col),
    .wdata (pix_in.pixel_in),
    .re    (in_fire),
    .raddr (col),
    .rdata (even_q)
  );

  pr3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_odd (
    .clk   (clk),
    .we    (in_fire && row[0]),
    .waddr (col),
    .wdata (pix_in.pixel_in),
    .re    (in_fire),
    .raddr (col),
    .rdata (odd_q)
  );

  // stage 1: window and filter
  typedef struct packed {
    logic          odd_row;
    logic          first_row;
    logic          first_col;
    logic          produce;
    logic          last;
    logic [PW-1:0] px;
  } s1_t;

  s1_t s1, s1_next;

  always_comb begin
    s1_next.odd_row   = row[0];
    s1_next.first_row = (row == ROWW'(1));
    s1_next.first_col = (col == COLW'(1));
    s1_next.produce   = col[0] && row[0] && ({1'b0, row} < h_even)
                        && ({1'b0, col} < w_even);
    s1_next.last      = ({1'b0, row} == h_even - (ROWW+1)'(1))
                        && ({1'b0, col} == w_even - (COLW+1)'(1));
    s1_next.px        = pix_in.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

  logic [PW-1:0] win [6];
  logic [PW-1:0] tap_top, tap_mid, tap_bot;
  logic [PW-1:0] lft0, lft1, lft2;
  logic [SW-1:0] sum;
  logic          out_valid;

  assign s1_go = s1_valid && (!s1.produce || !out_valid || pix_out.ready);

  always_comb begin
    tap_mid = even_q;
    tap_top = s1.first_row ? even_q : odd_q;
    tap_bot = s1.px;
    lft0    = s1.first_col ? win[0] : win[3];
    lft1    = s1.first_col ? win[1] : win[4];
    lft2    = s1.first_col ? win[2] : win[5];
    sum = (SW'(win[1]) << 2)
        + ((SW'(lft1) + SW'(tap_mid) + SW'(win[0]) + SW'(win[2])) << 1)
        + SW'(lft0) + SW'(lft2) + SW'(tap_top) + SW'(tap_bot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_go && s1.odd_row) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= tap_top;
      win[1] <= tap_mid;
      win[2] <= tap_bot;
    end
  end

  // output register
  logic [PW-1:0] pixel_q;
  logic          last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1.produce) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.produce) begin
      pixel_q <= sum[SW-1:SW-PW];
      last_q  <= s1.last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_out  = pixel_q;
  assign pix_out.frame_last = last_q;

`ifndef ASSERT_OFF
  a_last_produces: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.last |-> s1.produce)
    else $error("frame end flag on a position that gives no output");

  a_fire_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted pixel did not reach the filter stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1) && $stable(even_q) && $stable(odd_q))
    else $error("stalled filter stage lost its data");

  a_produce_odd: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.produce |-> s1.odd_row)
    else $error("output scheduled on an even row");
`endif

endmodule

// ----- hw/rtl/pr3_ram.sv -----
// ----------------------------------------------------------------------------
// pr3_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module pr3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for pyramid_reduce_3x3: raster pixel frames of many
// sizes go in over the valid/ready input channel, and every output pixel is
// checked against a built-in model of the 3x3 binomial reduce. Sizes cover
// the clamped extremes, odd sizes and size changes within a frame. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_W        = pr3_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H        = pr3_pkg::MAX_HEIGHT_DEF;
  localparam int SETTLE       = 6;
  localparam int STALL_LIMIT  = 500;
  localparam int RANDOM_ITEMS = 280;

  typedef struct packed {
    logic [pr3_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } level_pix_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [pr3_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pr3_pkg::CFG_DATA_W-1:0]  cfg_data;

  pr3_in_if  pix_in_ch ();
  pr3_out_if pix_out_ch ();

  pyramid_reduce_3x3 u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in_ch),
    .pix_out   (pix_out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  logic [pr3_pkg::WIDTH_REG_W-1:0]  width_reg  = pr3_pkg::WIDTH_RESET;
  logic [pr3_pkg::HEIGHT_REG_W-1:0] height_reg = pr3_pkg::HEIGHT_RESET;
  logic [pr3_pkg::PIX_W-1:0] even_line [MAX_W];
  logic [pr3_pkg::PIX_W-1:0] odd_line  [MAX_W];
  logic [pr3_pkg::PIX_W-1:0] window [6];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  level_pix_t expected_pixels [$];
  logic [pr3_pkg::PIX_W-1:0] pixel_q [$];

  int pixels_fed     = 0;
  int pixels_taken   = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  logic in_taken    = 1'b0;
  logic out_taken   = 1'b0;
  logic in_burst    = 1'b0;
  logic out_burst   = 1'b0;
  logic send_loaded = 1'b0;
  logic ready_armed = 1'b0;
  logic [pr3_pkg::PIX_W-1:0] send_pix;
  int send_wait   = 0;
  int ready_stall = 0;

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      even_line[i] = '0;
      odd_line[i]  = '0;
    end
    for (int i = 0; i < 6; i++) window[i] = '0;
  end

  task automatic reduce_pixel(input logic [pr3_pkg::PIX_W-1:0] px);
    int unsigned w, h, w_even, h_even, lb;
    logic [pr3_pkg::PIX_W-1:0] mid, top;
    logic [pr3_pkg::SUM_W-1:0] tap_sum;
    level_pix_t want;
    w = (width_reg < 2) ? 2 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg < 2) ? 2 : ((height_reg > MAX_H) ? MAX_H : height_reg);
    w_even = w & ~32'd1;
    h_even = h & ~32'd1;
    if (row_pos % 2 == 0) begin
      even_line[col_pos] = px;
    end else begin
      mid = even_line[col_pos];
      top = (row_pos == 1) ? mid : odd_line[col_pos];
      odd_line[col_pos] = px;
      if (col_pos % 2 == 1 && row_pos < h_even && col_pos < w_even) begin
        // left border repeats the centre column
        lb = (col_pos == 1) ? 0 : 3;
        tap_sum = pr3_pkg::SUM_W'(4 * window[1]
                + 2 * (window[lb+1] + mid + window[0] + window[2])
                + window[lb] + window[lb+2] + top + px);
        want.pixel = tap_sum[pr3_pkg::SUM_W-1:4];
        want.last  = (row_pos == h_even - 1) && (col_pos == w_even - 1);
        expected_pixels.insert(expected_pixels.size(), want);
      end
      window[3] = window[0];
      window[4] = window[1];
      window[5] = window[2];
      window[0] = top;
      window[1] = mid;
      window[2] = px;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // sample transfers, predict and check
  always @(posedge clk) begin : check_outputs
    level_pix_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          pr3_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[pr3_pkg::WIDTH_REG_W-1:0];
          end
          pr3_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[pr3_pkg::HEIGHT_REG_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (pix_in_ch.valid && pix_in_ch.ready) begin
        in_taken = 1'b1;
        reduce_pixel(pix_in_ch.pixel_in);
        pixels_taken++;
      end
      if (pix_out_ch.valid && pix_out_ch.ready) begin
        out_taken = 1'b1;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output: expected none, actual pixel %0d last %0b",
                   $time, pix_out_ch.pixel_out, pix_out_ch.frame_last);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_out_ch.pixel_out !== want.pixel) begin
            $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                     $time, want.pixel, pix_out_ch.pixel_out);
            mismatch_count++;
          end
          if (pix_out_ch.frame_last !== want.last) begin
            $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                     $time, want.last, pix_out_ch.frame_last);
            mismatch_count++;
          end
        end
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // input side: each pixel waits a random number of cycles before valid
  always @(negedge clk) begin : drive_pixels
    logic nxt_valid;
    logic [pr3_pkg::PIX_W-1:0] nxt_pix;
    nxt_valid = pix_in_ch.valid && !in_taken;
    nxt_pix   = pix_in_ch.pixel_in;
    if (!rst && !nxt_valid) begin
      if (!send_loaded && pixel_q.size() > 0) begin
        send_pix    = pixel_q.pop_front();
        send_loaded = 1'b1;
        if ($urandom_range(0, 47) == 0) in_burst = !in_burst;
        send_wait = in_burst ? 0 : $urandom_range(0, 14);
      end
      if (send_loaded) begin
        if (send_wait == 0) begin
          nxt_valid   = 1'b1;
          nxt_pix     = send_pix;
          send_loaded = 1'b0;
        end else begin
          send_wait--;
        end
      end
    end
    pix_in_ch.valid    <= nxt_valid;
    pix_in_ch.pixel_in <= nxt_pix;
  end

  // output side: ready held low for a random stall before each transfer
  always @(negedge clk) begin : drive_ready
    if (out_taken || !ready_armed) begin
      if ($urandom_range(0, 47) == 0) out_burst = !out_burst;
      ready_stall = out_burst ? 0 : $urandom_range(0, 14);
      ready_armed = 1'b1;
    end
    if (ready_stall > 0) begin
      pix_out_ch.ready <= 1'b0;
      ready_stall--;
    end else begin
      pix_out_ch.ready <= 1'b1;
    end
  end

  task automatic wait_quiet();
    while (pixels_taken != pixels_fed || expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pr3_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pr3_pkg::CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    logic hb;
    hb = 1'($urandom_range(0, 1));
    write_reg(pr3_pkg::REG_IMAGE_WIDTH, {hb, pr3_pkg::WIDTH_REG_W'(w)});
    write_reg(pr3_pkg::REG_IMAGE_HEIGHT, pr3_pkg::HEIGHT_REG_W'(h));
  endtask

  task automatic add_pixel(input logic [pr3_pkg::PIX_W-1:0] px);
    pixel_q.insert(pixel_q.size(), px);
  endtask

  task automatic feed_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_pixel(8'd0);
        1: add_pixel(8'd255);
        default: add_pixel(pr3_pkg::PIX_W'($urandom_range(0, 255)));
      endcase
    end
    pixels_fed += n;
    wait_quiet();
  endtask

  // run the raster counters to the frame end under the size in use
  task automatic finish_frame(input int wc, input int hc);
    int unsigned c, r;
    int n;
    c = col_pos;
    r = row_pos;
    n = 0;
    do begin
      n++;
      if (c + 1 >= wc) begin
        c = 0;
        r = (r + 1 >= hc) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
    end while (c != 0 || r != 0);
    feed_random(n);
  endtask

  initial begin : stimulus
    int w, h, wc, hc, stop_at;
    rst                 = 1'b1;
    cfg_wen             = 1'b0;
    cfg_index           = pr3_pkg::REG_IMAGE_WIDTH;
    cfg_data            = '0;
    pix_in_ch.valid     = 1'b0;
    pix_in_ch.pixel_in  = '0;
    pix_out_ch.ready    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 4x4 frame: full-scale top half, black bottom half
    set_size(4, 4);
    repeat (8) add_pixel(8'd255);
    repeat (8) add_pixel(8'd0);
    pixels_fed += 16;
    wait_quiet();

    // width below range, odd height: last row stored but never output
    set_size(1, 3);
    add_pixel(8'd0);
    add_pixel(8'd255);
    add_pixel(8'd255);
    add_pixel(8'd0);
    add_pixel(8'd17);
    add_pixel(8'd200);
    pixels_fed += 6;
    wait_quiet();

    // fills every line memory entry that the random sizes reach
    set_size(14, 2);
    feed_random(28);

    // width above range clamps to the maximum, cut short by a size change
    set_size(12'hfff, 2);
    feed_random(40);
    set_size(6, 4);
    finish_frame(6, 4);

    // width clamps up to 2, height above range clamps to the maximum
    set_size(0, 13'h1fff);
    feed_random(40);
    set_size(4, 4);
    finish_frame(4, 4);

    stop_at = pixels_fed + RANDOM_ITEMS;
    while (pixels_fed < stop_at) begin
      w = $urandom_range(0, 14);
      h = $urandom_range(0, 10);
      set_size(w, h);
      wc = (w < 2) ? 2 : w;
      hc = (h < 2) ? 2 : h;
      if ($urandom_range(0, 3) == 0) begin
        // change size part way through a frame, then run to the frame end
        feed_random($urandom_range(1, wc * hc - 1));
        w = $urandom_range(0, 14);
        h = $urandom_range(0, 10);
        set_size(w, h);
        wc = (w < 2) ? 2 : w;
        hc = (h < 2) ? 2 : h;
        finish_frame(wc, hc);
      end else begin
        feed_random(wc * hc * $urandom_range(1, 3));
      end
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pr3_pkg.sv
hw/rtl/pr3_if.sv
hw/rtl/pr3_ram.sv
hw/rtl/pyramid_reduce_3x3.sv
tb/sv/testbench.sv
